// File: design/srjs_pkg.sv
// Shared types and constants of the shortest-remaining-job scheduler.
// Used by srjs_table and shortest_remaining_job_scheduler_top; no dependencies.
package srjs_pkg;

  localparam int SLOTS  = 16;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int ID_W   = 8;
  localparam int TIME_W = 16;
  localparam int SUM_W  = 20;
  localparam int CNT_W  = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SLOTS - 1);

  localparam logic REG_PREEMPTIVE = 1'b0;
  localparam logic REG_JOB_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              load_en;
    logic [IDX_W-1:0]  load_slot;
    logic [ID_W-1:0]   load_job;
    logic [TIME_W-1:0] load_arrival;
    logic [TIME_W-1:0] load_burst;
    logic              rem_en;
    logic [IDX_W-1:0]  rem_slot;
    logic [TIME_W-1:0] rem_val;
  } tbl_wr_t;

  typedef struct packed {
    logic [ID_W-1:0]   job;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] rem;
  } tbl_rd_t;

endpackage

// File: design/srjs_table.sv
// Job table of the scheduler: id, arrival, burst and remaining time per slot.
// One read address, a load write port and a remaining-time write port; uses srjs_pkg.
module srjs_table (
  input  logic                     clk,
  input  logic                     rst,
  input  srjs_pkg::tbl_wr_t        wr,
  input  logic [srjs_pkg::IDX_W-1:0] rd_addr,
  output srjs_pkg::tbl_rd_t        rd
);
  import srjs_pkg::*;

  logic [ID_W-1:0]   job_mem [SLOTS];
  logic [TIME_W-1:0] arr_mem [SLOTS];
  logic [TIME_W-1:0] bur_mem [SLOTS];
  logic [TIME_W-1:0] rem_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.load_en) begin
      job_mem[wr.load_slot] <= wr.load_job;
      arr_mem[wr.load_slot] <= wr.load_arrival;
      bur_mem[wr.load_slot] <= wr.load_burst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        rem_mem[i] <= '0;
      end
    end else if (wr.load_en) begin
      rem_mem[wr.load_slot] <= wr.load_burst;
    end else if (wr.rem_en) begin
      rem_mem[wr.rem_slot] <= wr.rem_val;
    end
  end

  assign rd.job     = job_mem[rd_addr];
  assign rd.arrival = arr_mem[rd_addr];
  assign rd.burst   = bur_mem[rd_addr];
  assign rd.rem     = rem_mem[rd_addr];

endmodule

// File: design/shortest_remaining_job_scheduler_top.sv
// Shortest-remaining-time / shortest-job-first scheduler, top level.
// Holds the sequencer, time and totals; instantiates srjs_table; uses srjs_pkg.
//
// A transaction is taken when start is high and busy is low; busy then stays
// high until the result is produced. Every transaction walks the whole job
// table, one slot per cycle through the single table read port and one
// remaining-time comparator; a tick adds an update step after the walk,
// and every op ends with a finish step before the result is shown.
// The result appears on the output ports for exactly one cycle with strobe
// high, and the next transaction may be started in that same cycle. The
// receiver cannot stall; capture the result when strobe is high.
module shortest_remaining_job_scheduler_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic [srjs_pkg::IDX_W-1:0]  slot,
  input  logic [srjs_pkg::ID_W-1:0]   job_id,
  input  logic [srjs_pkg::TIME_W-1:0] arrival,
  input  logic [srjs_pkg::TIME_W-1:0] burst,
  input  logic                        wr_en,
  input  logic                        wr_index,
  input  logic [srjs_pkg::CNT_W-1:0]  wr_data,
  output logic                        strobe,
  output logic [srjs_pkg::ID_W-1:0]   running_id,
  output logic                        idle,
  output logic                        job_done,
  output logic [srjs_pkg::TIME_W-1:0] turnaround,
  output logic [srjs_pkg::TIME_W-1:0] waiting,
  output logic [srjs_pkg::TIME_W-1:0] time_now,
  output logic [srjs_pkg::SUM_W-1:0]  total_waiting,
  output logic [srjs_pkg::SUM_W-1:0]  total_turnaround,
  output logic [srjs_pkg::TIME_W-1:0] idle_total,
  output logic                        all_done
);
  import srjs_pkg::*;

  state_t state, state_next;
  op_t    op_r;

  logic              preemptive;
  logic [CNT_W-1:0]  job_count;
  logic [TIME_W-1:0] clock_time;
  logic [TIME_W-1:0] idle_sum;
  logic [SUM_W-1:0]  waiting_sum;
  logic [SUM_W-1:0]  turnaround_sum;
  logic [IDX_W-1:0]  held_slot;
  logic              holding;

  logic [IDX_W-1:0]  idx;
  logic              found;
  logic [IDX_W-1:0]  pick;
  logic [TIME_W-1:0] best_rem;
  logic              held_ok;
  logic              seen1;
  logic              seen2;
  logic              done_r;
  logic              idle_r;
  logic [ID_W-1:0]   run_id_r;
  logic [TIME_W-1:0] turn_r;
  logic [TIME_W-1:0] burst_r;

  tbl_wr_t           tbl_wr;
  tbl_rd_t           rd;
  logic [IDX_W-1:0]  rd_addr;

  logic              accept;
  logic              counted;
  logic              ready;
  logic              nz;
  logic              use_held;
  logic              sel_found;
  logic [IDX_W-1:0]  sel_slot;
  logic [TIME_W-1:0] time_inc;
  logic [TIME_W-1:0] idle_inc;
  logic [TIME_W-1:0] rem_dec;
  logic [TIME_W-1:0] turn_v;
  logic [TIME_W-1:0] wait_v;
  logic [SUM_W:0]    tw_add;
  logic [SUM_W:0]    tt_add;
  logic [SUM_W-1:0]  tw_next;
  logic [SUM_W-1:0]  tt_next;
  logic              pending;

  srjs_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;

  assign counted = (CNT_W'(idx) < job_count);
  assign ready   = counted && (rd.rem != '0) && (rd.arrival <= clock_time);
  assign nz      = counted && (((op_r == OP_RESTART) ? rd.burst : rd.rem) != '0);

  assign use_held  = holding && !preemptive && held_ok;
  assign sel_found = use_held || found;
  assign sel_slot  = use_held ? held_slot : pick;
  assign rd_addr   = (state == ST_UPD) ? sel_slot : idx;

  assign time_inc = (clock_time == TIME_MAX) ? clock_time : clock_time + 1'b1;
  assign idle_inc = (idle_sum == TIME_MAX) ? idle_sum : idle_sum + 1'b1;
  assign rem_dec  = rd.rem - 1'b1;
  assign turn_v   = (time_inc >= rd.arrival) ? time_inc - rd.arrival : '0;
  assign wait_v   = (turn_r >= burst_r) ? turn_r - burst_r : '0;

  assign tw_add  = {1'b0, waiting_sum} + (SUM_W + 1)'(wait_v);
  assign tt_add  = {1'b0, turnaround_sum} + (SUM_W + 1)'(turn_r);
  assign tw_next = tw_add[SUM_W] ? SUM_MAX : tw_add[SUM_W-1:0];
  assign tt_next = tt_add[SUM_W] ? SUM_MAX : tt_add[SUM_W-1:0];
  assign pending = seen2 || (seen1 && !done_r);

  always_comb begin
    state_next          = state;
    tbl_wr.load_en      = accept && (op_t'(op) == OP_LOAD);
    tbl_wr.load_slot    = slot;
    tbl_wr.load_job     = job_id;
    tbl_wr.load_arrival = arrival;
    tbl_wr.load_burst   = burst;
    tbl_wr.rem_en       = 1'b0;
    tbl_wr.rem_slot     = idx;
    tbl_wr.rem_val      = rd.burst;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        tbl_wr.rem_en = (op_r == OP_RESTART);
        if (idx == LAST_IDX) begin
          state_next = (op_r == OP_TICK) ? ST_UPD : ST_FIN;
        end
      end
      ST_UPD: begin
        tbl_wr.rem_en   = sel_found;
        tbl_wr.rem_slot = sel_slot;
        tbl_wr.rem_val  = rem_dec;
        state_next      = ST_FIN;
      end
      ST_FIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preemptive <= 1'b1;
      job_count  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PREEMPTIVE: preemptive <= wr_data[0];
        REG_JOB_COUNT:  job_count  <= wr_data;
        default:        job_count  <= job_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_time     <= '0;
      idle_sum       <= '0;
      waiting_sum    <= '0;
      turnaround_sum <= '0;
      held_slot      <= '0;
      holding        <= 1'b0;
      strobe         <= 1'b0;
    end else begin
      strobe <= (state == ST_FIN);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_r     <= op_t'(op);
            idx      <= '0;
            found    <= 1'b0;
            held_ok  <= 1'b0;
            seen1    <= 1'b0;
            seen2    <= 1'b0;
            done_r   <= 1'b0;
            idle_r   <= 1'b0;
            run_id_r <= '0;
            turn_r   <= '0;
            burst_r  <= '0;
            if (op_t'(op) == OP_LOAD && holding && held_slot == slot) begin
              holding <= 1'b0;
            end
            if (op_t'(op) == OP_RESTART) begin
              clock_time     <= '0;
              idle_sum       <= '0;
              waiting_sum    <= '0;
              turnaround_sum <= '0;
              held_slot      <= '0;
              holding        <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          idx <= idx + 1'b1;
          if (ready && (!found || rd.rem < best_rem)) begin
            found    <= 1'b1;
            pick     <= idx;
            best_rem <= rd.rem;
          end
          if (ready && idx == held_slot) begin
            held_ok <= 1'b1;
          end
          if (nz) begin
            seen1 <= 1'b1;
            seen2 <= seen2 || seen1;
          end
        end
        ST_UPD: begin
          clock_time <= time_inc;
          if (!sel_found) begin
            idle_r   <= 1'b1;
            idle_sum <= idle_inc;
            holding  <= 1'b0;
          end else begin
            run_id_r <= rd.job;
            burst_r  <= rd.burst;
            if (rem_dec == '0) begin
              done_r  <= 1'b1;
              turn_r  <= turn_v;
              holding <= 1'b0;
            end else begin
              holding   <= !preemptive;
              held_slot <= sel_slot;
            end
          end
        end
        ST_FIN: begin
          if (done_r) begin
            waiting_sum    <= tw_next;
            turnaround_sum <= tt_next;
          end
          running_id       <= run_id_r;
          idle             <= idle_r;
          job_done         <= done_r;
          turnaround       <= done_r ? turn_r : '0;
          waiting          <= done_r ? wait_v : '0;
          time_now         <= clock_time;
          total_waiting    <= done_r ? tw_next : waiting_sum;
          total_turnaround <= done_r ? tt_next : turnaround_sum;
          idle_total       <= idle_sum;
          all_done         <= !pending;
        end
        default: begin
          holding <= 1'b0;
        end
      endcase
    end
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (state == ST_IDLE))
    else $error("result shown while a transaction is still in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && state == ST_SCAN && idx == '0))
    else $error("accepted transaction did not start the table walk");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("two results in consecutive cycles");

  a_done_not_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && job_done) |-> (!idle && all_done == !pending))
    else $error("completion reported on an idle tick");

  a_idle_no_id: assert property (@(posedge clk) disable iff (rst)
    (strobe && idle) |-> (running_id == '0 && !job_done))
    else $error("idle tick reports a running job");

endmodule
